[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge, masked during reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check a property on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

[design/mmdd_pkg.sv]
// ----------------------------------------------------------------------------
// mmdd_pkg
// Shared widths, constants and types of the moving mean deviation detector.
// ----------------------------------------------------------------------------
package mmdd_pkg;

  // Window depth, a power of two
  localparam int WINDOW_DEPTH = 8;

  localparam int SAMPLE_W = 16;
  localparam int THR_W    = 16;
  localparam int DEV_W    = 19;
  localparam int PTR_W    = $clog2(WINDOW_DEPTH);
  localparam int FILL_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W    = SAMPLE_W + PTR_W;

  localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd307;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [THR_W-1:0]    threshold_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [DEV_W-1:0]    deviation_t;

  // Outcome of the deviation test for one sample
  typedef struct packed {
    logic hit;
    sum_t dev;
  } cmp_result_t;

endpackage

[design/mmdd_window.sv]
// ----------------------------------------------------------------------------
// mmdd_window
// Sample ring, running sum, write pointer and warm-up count.
// ----------------------------------------------------------------------------
module mmdd_window (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  mmdd_pkg::sample_t sample,
  output mmdd_pkg::sum_t   window_sum,
  output logic             window_full
);
  import mmdd_pkg::*;

  sample_t            ring [WINDOW_DEPTH];
  logic [PTR_W-1:0]   write_pointer;
  logic [FILL_W-1:0]  fill_count;
  sum_t               sum;
  sum_t               sum_next;
  sample_t            oldest;

  assign window_full = (fill_count == FILL_W'(WINDOW_DEPTH));
  assign window_sum  = sum;
  assign oldest      = ring[write_pointer];

  // Swap the oldest entry for the new sample once the window is full
  always_comb begin
    if (window_full) begin
      sum_next = sum - SUM_W'(oldest) + SUM_W'(sample);
    end else begin
      sum_next = sum + SUM_W'(sample);
    end
  end

  // Overwrite the oldest ring slot
  always_ff @(posedge clk) begin
    if (advance) begin
      ring[write_pointer] <= sample;
    end
  end

  // Advance pointer, sum and warm-up count
  always_ff @(posedge clk) begin
    if (rst) begin
      write_pointer <= '0;
      fill_count    <= '0;
      sum           <= '0;
    end else if (advance) begin
      write_pointer <= write_pointer + 1'b1;
      sum           <= sum_next;
      if (!window_full) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

endmodule

[design/mmdd_compare.sv]
// ----------------------------------------------------------------------------
// mmdd_compare
// Scaled absolute deviation of a sample from the window mean and its test
// against the scaled threshold.
// ----------------------------------------------------------------------------
module mmdd_compare (
  input  mmdd_pkg::sample_t     sample,
  input  mmdd_pkg::sum_t        window_sum,
  input  logic                  window_full,
  input  mmdd_pkg::threshold_t  threshold,
  output mmdd_pkg::cmp_result_t result
);
  import mmdd_pkg::*;

  sum_t scaled;
  sum_t limit;
  sum_t dev;

  // Scale by the window depth with a shift
  assign scaled = {sample, PTR_W'(0)};
  assign limit  = {threshold, PTR_W'(0)};

  // Take the absolute difference
  assign dev = (scaled >= window_sum) ? (scaled - window_sum) : (window_sum - scaled);

  // Flag only a strictly larger deviation on a full window
  assign result.hit = window_full && (dev > limit);
  assign result.dev = dev;

endmodule

[design/moving_mean_deviation_detector.sv]
// ----------------------------------------------------------------------------
// moving_mean_deviation_detector
// Flags acceleration samples that stray from the mean of the last samples.
// ----------------------------------------------------------------------------
// Takes one sample per clock cycle. A taken sample sits in the input register
// and moves into the result register once that register is free; the result
// register offers a flagged result, which transfers when out_ready is high.
// While a result waits for out_ready, the held sample cannot move on and the
// input stalls. The first WINDOW_DEPTH samples only fill the window; each
// later sample is checked against the running window sum in the cycle it
// leaves the input register, and the sum, the ring write and the result load
// all happen in that one cycle. A result appears only when the scaled
// deviation exceeds the scaled threshold. The threshold register is written
// through the cfg port, which is always ready; write it only while no sample
// is in flight.
`include "assert_macros.svh"

module moving_mean_deviation_detector (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  mmdd_pkg::threshold_t  cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mmdd_pkg::sample_t     sample_magnitude,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mmdd_pkg::deviation_t  scaled_deviation
);
  import mmdd_pkg::*;

  threshold_t  threshold;
  logic        s1_valid;
  sample_t     s1_sample;
  logic        advance;
  sum_t        window_sum;
  logic        window_full;
  cmp_result_t cmp;

  // Move the held sample on when the result register can take it
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;
  assign cfg_ready = 1'b1;

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
    end else if (cfg_valid) begin
      threshold <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample <= sample_magnitude;
    end
  end

  mmdd_window u_window (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .sample      (s1_sample),
    .window_sum  (window_sum),
    .window_full (window_full)
  );

  mmdd_compare u_compare (
    .sample      (s1_sample),
    .window_sum  (window_sum),
    .window_full (window_full),
    .threshold   (threshold),
    .result      (cmp)
  );

  // Result register: load on a hit, drop after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= cmp.hit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && cmp.hit) begin
      scaled_deviation <= DEV_W'(cmp.dev);
    end
  end

  `ASSERT_ALWAYS(a_reset_empty, clk, rst |=> (!out_valid && !s1_valid), "pipeline not empty after reset")
  `ASSERT_CLK(a_no_spurious_result, clk, rst, (!s1_valid && (!out_valid || out_ready)) |=> !out_valid, "result without a sample")
  `ASSERT_CLK(a_stall_holds_sample, clk, rst, (s1_valid && out_valid && !out_ready) |=> (s1_valid && $stable(s1_sample)), "held sample lost on stall")

endmodule

[verif/moving_mean_deviation_detector_tb.sv]
// ----------------------------------------------------------------------------
// moving_mean_deviation_detector_tb
// Self-checking bench for the moving mean deviation detector. A predictor
// tracks the window ring, its running sum and the threshold. Each accepted
// sample that should flag queues its scaled deviation. A monitor compares every
// result transfer with the oldest queued value. Directed warm-up and boundary
// cases run first. Random phases with sender idling and receiver stalls follow,
// then a long receiver hold-off.
// ----------------------------------------------------------------------------
module moving_mean_deviation_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mmdd_pkg::*;

  localparam int          CLK_PERIOD    = 10;
  localparam int          RESET_CYCLES  = 5;
  // pipeline has an input and a result register; leave margin for items that flag nothing
  localparam int          SETTLE_CYCLES = 6;
  localparam int          HOLD_CYCLES   = 200;
  localparam int          PHASE_ITEMS   = 370;
  localparam int unsigned CYCLE_LIMIT   = 500000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  threshold_t cfg_data = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  sample_t    sample_magnitude = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  deviation_t scaled_deviation;

  // predictor state
  sample_t     window_ring [WINDOW_DEPTH];
  int unsigned ring_ptr = 0;
  int unsigned warm_count = 0;
  int unsigned run_sum = 0;
  threshold_t  thr_model = THRESHOLD_RESET;
  deviation_t  pending_deviations [$];

  // idling controls
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int holds_granted = 0;
  int hold_left = 0;

  // bookkeeping
  int unsigned cycle_count = 0;
  int          samples_sent = 0;
  int          results_checked = 0;
  int          mismatches = 0;
  deviation_t  want_dev;

  moving_mean_deviation_detector uut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .sample_magnitude (sample_magnitude),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .scaled_deviation (scaled_deviation)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycle_count);
      $display("tb: failure");
      $finish;
    end
  end

  // Drive out_ready: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_granted != hold_requests) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      holds_granted <= holds_granted + 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("tb: mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Check each result transfer against the oldest expected deviation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_checked++;
      if (pending_deviations.size() == 0) begin
        report_mismatch("unexpected result", scaled_deviation, 0);
      end else begin
        want_dev = pending_deviations.pop_front();
        if (scaled_deviation !== want_dev)
          report_mismatch("scaled_deviation", scaled_deviation, want_dev);
      end
    end
  end

  // Advance the window by one sample and queue the deviation it flags
  function automatic void predict_deviation(input sample_t s);
    int unsigned scaled;
    int unsigned dev;
    int unsigned limit;
    if (warm_count < WINDOW_DEPTH) begin
      window_ring[ring_ptr] = s;
      run_sum += s;
      ring_ptr = (ring_ptr + 1) % WINDOW_DEPTH;
      warm_count++;
    end else begin
      scaled = 32'(s) * WINDOW_DEPTH;
      dev = (scaled >= run_sum) ? scaled - run_sum : run_sum - scaled;
      limit = 32'(thr_model) * WINDOW_DEPTH;
      run_sum = run_sum - window_ring[ring_ptr] + s;
      window_ring[ring_ptr] = s;
      ring_ptr = (ring_ptr + 1) % WINDOW_DEPTH;
      if (dev > limit)
        pending_deviations.push_back(deviation_t'(dev));
    end
  endfunction

  // Offer one sample, idling first at random; valid stays high on return
  task automatic send_sample(input sample_t s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample_magnitude <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_deviation(s);
    samples_sent++;
  endtask

  // Drop valid, wait out all expected results, then let the pipeline settle
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (pending_deviations.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the threshold register; call only while the block is idle
  task automatic write_threshold(input threshold_t thr);
    cfg_valid <= 1'b1;
    cfg_data <= thr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    thr_model = thr;
  endtask

  // Warm-up at the reset threshold, then a deviation exactly at the threshold and two extreme samples
  task automatic test_warmup_and_boundary();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (WINDOW_DEPTH) send_sample(16'd1000);
    send_sample(16'd1000 + THRESHOLD_RESET);
    send_sample(16'd0);
    send_sample(16'hFFFF);
    wait_for_idle();
  endtask

  // Zero threshold and full-scale threshold, with the largest deviation
  task automatic test_threshold_extremes();
    write_threshold(16'd0);
    repeat (WINDOW_DEPTH) send_sample(16'd0);
    send_sample(16'd0);
    send_sample(16'hFFFF);
    wait_for_idle();
    write_threshold(16'hFFFF);
    send_sample(16'd0);
    wait_for_idle();
  endtask

  // Samples near a drifting baseline, with occasional full-range spikes
  task automatic run_random_items(input int count);
    int      base;
    int      v;
    sample_t s;
    base = $urandom_range(0, 65535);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 39) == 0)
        base = $urandom_range(0, 65535);
      if ($urandom_range(0, 99) < 12) begin
        s = sample_t'($urandom_range(0, 65535));
      end else begin
        v = base + int'($urandom_range(0, 1600)) - 800;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        s = sample_t'(v);
      end
      send_sample(s);
    end
  endtask

  // Random phases under each idling mix, with a new threshold per phase
  task automatic test_random_phases();
    int send_mix [4] = '{0, 88, 0, 28};
    int recv_mix [4] = '{0, 0, 88, 28};
    for (int p = 0; p < 4; p++) begin
      wait_for_idle();
      if (p == 0)
        write_threshold(threshold_t'($urandom_range(0, 65535)));
      else
        write_threshold(threshold_t'($urandom_range(0, 700)));
      send_idle_pct = send_mix[p];
      recv_stall_pct = recv_mix[p];
      run_random_items(PHASE_ITEMS);
    end
    wait_for_idle();
  endtask

  // Hold off the receiver while every sample flags, so the input stalls
  task automatic test_output_hold_off();
    sample_t s;
    write_threshold(16'd0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_requests <= hold_requests + 1;
    for (int i = 0; i < 40; i++) begin
      s = (i % 2 == 0) ? sample_t'($urandom_range(0, 1000))
                       : sample_t'($urandom_range(64535, 65535));
      send_sample(s);
    end
    wait_for_idle();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_warmup_and_boundary();
    test_threshold_extremes();
    test_random_phases();
    test_output_hold_off();
    wait_for_idle();

    $display("tb: %0d samples sent, %0d deviation results checked, %0d mismatches",
             samples_sent, results_checked, mismatches);
    $display("tb: covered warm-up, threshold equality and extremes, idle/stall mixes, hold-off");
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
